>>> rtl/harrs_pkg.sv
// harrs_pkg: shared types and codes for the health-aware round-robin selector.
// No dependencies.
`default_nettype none
package harrs_pkg;

  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int SLOT_PORT_W = 4;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int RATIO_W = 9;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_SELECT = 2'd0,
    OP_REPORT = 2'd1,
    OP_ADD    = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_NONE       = 2'd1,
    ST_NO_SLOT    = 2'd2,
    ST_RESERVED   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAIL_WINDOW = 3'd0,
    CFG_CHECK_INTV  = 3'd1,
    CFG_CONSEC_LIM  = 3'd2,
    CFG_RETRY_INTV  = 3'd3,
    CFG_MIN_CALLS   = 3'd4,
    CFG_ERR_RATIO   = 3'd5,
    CFG_UNUSED6     = 3'd6,
    CFG_UNUSED7     = 3'd7
  } cfg_idx_e;

  // Request carried from the front to the back through the queue.
  typedef struct packed {
    op_e                  op;
    logic [SLOT_PORT_W-1:0] slot;
    logic                 ok;
    logic [TIME_W-1:0]    now;
    logic [CFG_W-1:0]     rnd;
  } req_t;

  typedef struct packed {
    logic [SLOT_PORT_W-1:0] chosen;
    status_e                status;
  } res_t;

  typedef struct packed {
    logic [CFG_W-1:0]   fail_window;
    logic [CFG_W-1:0]   check_intv;
    logic [CFG_W-1:0]   consec_lim;
    logic [CFG_W-1:0]   retry_intv;
    logic [CFG_W-1:0]   min_calls;
    logic [RATIO_W-1:0] err_ratio;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/harrs_fifo.sv
// harrs_fifo: small two-entry register queue between front and back.
// Depends on nothing but its width parameter.
`default_nettype none
module harrs_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  // Write and advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end
endmodule
`default_nettype wire

>>> rtl/harrs_back.sv
// harrs_back: slot table and the sequencer that carries out one request.
// Depends on harrs_pkg.
`default_nettype none
module harrs_back #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire harrs_pkg::cfg_t  cfg_i,
  input  wire logic             req_valid_i,
  input  wire harrs_pkg::req_t  req_i,
  output logic                  req_pop_o,
  output logic                  res_push_o,
  output harrs_pkg::res_t       res_o,
  input  wire logic             res_full_i
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = SW + 1;
  localparam int TW = harrs_pkg::TIME_W;
  localparam int PW = harrs_pkg::SLOT_PORT_W;
  localparam int DW = CW + 17;
  localparam int MW = COUNT_BITS + 17;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [SW:0] NSL = CW'(NUM_SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_RPT2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [NUM_SLOTS-1:0]  pres_q, avail_q;
  logic [COUNT_BITS-1:0] succ_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0] err_q  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] cons_q [NUM_SLOTS];
  logic [TW-1:0]         cdl_q  [NUM_SLOTS];
  logic [TW-1:0]         kdl_q  [NUM_SLOTS];
  logic [TW-1:0]         rty_q  [NUM_SLOTS];

  logic [2:0]    state_q;
  logic [SW-1:0] start_q;
  logic [CW-1:0] k_q, cnt_q;
  logic [16:0]   rem_q;
  logic [4:0]    mbit_q;
  harrs_pkg::res_t res_q;

  // Cursor and slot under examination
  logic [SW-1:0] cur;
  logic [CW-1:0] sum;
  assign sum = {1'b0, start_q} + k_q;
  assign cur = (sum >= NSL) ? SW'(sum - NSL) : sum[SW-1:0];

  logic [CW-1:0] pcount;
  always_comb begin
    pcount = '0;
    for (int i = 0; i < NUM_SLOTS; i++) pcount = pcount + CW'(pres_q[i]);
  end

  // Report slot view
  logic [SW-1:0] rs;
  logic          rs_ok;
  assign rs    = SW'(req_i.slot);
  assign rs_ok = (NUM_SLOTS >= (1 << PW)) ? 1'b1 : ({1'b0, req_i.slot} < (PW+1)'(NUM_SLOTS));
  logic rs_pres;
  assign rs_pres = rs_ok && pres_q[rs];

  logic [COUNT_BITS-1:0] cons_inc, err_inc, succ_inc;
  assign cons_inc = (cons_q[rs] == CMAX) ? CMAX : cons_q[rs] + 1'b1;
  assign err_inc  = (err_q[rs]  == CMAX) ? CMAX : err_q[rs] + 1'b1;
  assign succ_inc = (succ_q[rs] == CMAX) ? CMAX : succ_q[rs] + 1'b1;

  logic [TW-1:0] cdl_new;
  assign cdl_new = (cons_q[rs] == '0) ? req_i.now + TW'(cfg_i.fail_window) : cdl_q[rs];
  logic trip;
  assign trip = (32'(cons_inc) >= 32'(cfg_i.consec_lim)) && (req_i.now >= cdl_new);

  // Ratio operands, registered ahead of the multiply compare
  logic [COUNT_BITS:0] tot_q;
  logic [COUNT_BITS-1:0] e_q;
  logic [COUNT_BITS+9:0] lhs, rhs;
  assign lhs = {2'b00, e_q, 8'd0};
  assign rhs = (COUNT_BITS+10)'(cfg_i.err_ratio) * (COUNT_BITS+10)'(tot_q);

  // Divisor shifted to the current remainder step
  logic [DW-1:0] msub;
  assign msub = DW'(cnt_q) << (mbit_q - 5'd1);

  assign req_pop_o  = state_q == S_DONE && !res_full_i;
  assign res_push_o = req_pop_o;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= '0;
      pres_q  <= '0;
      avail_q <= '0;
      k_q     <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      mbit_q  <= '0;
      res_q   <= '0;
      tot_q   <= '0;
      e_q     <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        succ_q[i] <= '0; err_q[i] <= '0; cons_q[i] <= '0;
        cdl_q[i] <= '0; kdl_q[i] <= '0; rty_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            res_q <= '{chosen: '0, status: harrs_pkg::ST_OK};
            state_q <= S_DONE;
            case (req_i.op)
              harrs_pkg::OP_SELECT: begin
                if (pcount == '0) res_q.status <= harrs_pkg::ST_NONE;
                else begin
                  k_q <= '0;
                  cnt_q <= pcount;
                  state_q <= S_SCAN;
                end
              end
              harrs_pkg::OP_REPORT: begin
                if (!rs_pres) res_q.status <= harrs_pkg::ST_NO_SLOT;
                else if (!avail_q[rs]) begin
                  if (req_i.ok) begin
                    avail_q[rs] <= 1'b1;
                    succ_q[rs] <= COUNT_BITS'(1);
                    err_q[rs] <= '0;
                    cons_q[rs] <= '0;
                    cdl_q[rs] <= req_i.now + TW'(cfg_i.fail_window);
                    kdl_q[rs] <= req_i.now + TW'(cfg_i.check_intv);
                  end else err_q[rs] <= err_inc;
                end else if (req_i.ok) begin
                  succ_q[rs] <= succ_inc;
                  cons_q[rs] <= '0;
                  tot_q <= {1'b0, succ_inc} + {1'b0, err_q[rs]};
                  e_q <= err_q[rs];
                  state_q <= S_RPT2;
                end else begin
                  err_q[rs] <= err_inc;
                  cdl_q[rs] <= cdl_new;
                  cons_q[rs] <= cons_inc;
                  if (trip) begin
                    avail_q[rs] <= 1'b0;
                    rty_q[rs] <= req_i.now + TW'(cfg_i.retry_intv);
                  end else begin
                    tot_q <= {1'b0, succ_q[rs]} + {1'b0, err_inc};
                    e_q <= err_inc;
                    state_q <= S_RPT2;
                  end
                end
              end
              harrs_pkg::OP_ADD: begin
                if (!rs_ok) res_q.status <= harrs_pkg::ST_NO_SLOT;
                else if (!pres_q[rs]) begin
                  pres_q[rs] <= 1'b1; avail_q[rs] <= 1'b1;
                  succ_q[rs] <= '0; err_q[rs] <= '0; cons_q[rs] <= '0;
                  cdl_q[rs] <= '0; kdl_q[rs] <= '0; rty_q[rs] <= '0;
                end
              end
              default: begin
                if (!rs_pres) res_q.status <= harrs_pkg::ST_NO_SLOT;
                else begin
                  pres_q[rs] <= 1'b0; avail_q[rs] <= 1'b0;
                  succ_q[rs] <= '0; err_q[rs] <= '0; cons_q[rs] <= '0;
                  cdl_q[rs] <= '0; kdl_q[rs] <= '0; rty_q[rs] <= '0;
                end
              end
            endcase
          end
        end
        // Periodic error-ratio round
        S_RPT2: begin
          if (req_i.now >= kdl_q[rs]) begin
            kdl_q[rs] <= req_i.now + TW'(cfg_i.check_intv);
            if (!req_i.ok && MW'(tot_q) >= MW'(cfg_i.min_calls) && lhs >= rhs) begin
              avail_q[rs] <= 1'b0;
              rty_q[rs] <= req_i.now + TW'(cfg_i.retry_intv);
            end else begin
              succ_q[rs] <= '0;
              err_q[rs] <= '0;
            end
          end
          state_q <= S_DONE;
        end
        // Probe one slot per cycle
        S_SCAN: begin
          if (pres_q[cur] && (avail_q[cur] || req_i.now >= rty_q[cur])) begin
            if (!avail_q[cur]) rty_q[cur] <= req_i.now + TW'(cfg_i.retry_intv);
            res_q.chosen <= PW'(cur);
            start_q <= (cur == SW'(NUM_SLOTS - 1)) ? '0 : cur + 1'b1;
            state_q <= S_DONE;
          end else if (k_q == CW'(NUM_SLOTS - 1)) begin
            rem_q <= {1'b0, req_i.rnd};
            mbit_q <= 5'd16;
            state_q <= S_MOD;
          end else k_q <= k_q + 1'b1;
        end
        // Restoring remainder, one quotient bit per cycle
        S_MOD: begin
          if (DW'(rem_q) >= msub) begin
            rem_q <= 17'(DW'(rem_q) - msub);
          end
          mbit_q <= mbit_q - 5'd1;
          if (mbit_q == 5'd1) begin
            k_q <= '0;
            state_q <= S_PICK;
          end
        end
        // Count present slots from the start pointer
        S_PICK: begin
          if (pres_q[cur]) begin
            if (rem_q == '0) begin
              res_q.chosen <= PW'(cur);
              state_q <= S_DONE;
            end else rem_q <= rem_q - 1'b1;
          end
          k_q <= k_q + 1'b1;
        end
        S_DONE: begin
          if (!res_full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/health_aware_round_robin_selector.sv
// Top level of the health-aware round-robin selector: configuration registers,
// request and result queues, and the back-end sequencer. Depends on harrs_pkg, harrs_fifo and harrs_back.
// A select scans the slots one per cycle from the start pointer; a select where
// every node is blocked does a full scan, 16 remainder steps and up to NUM_SLOTS
// counting steps. A report to a live node that does not take it down also runs
// the error-ratio round; add, remove and other reports go straight to the result.
`default_nettype none
module health_aware_round_robin_selector #(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  node_slot_i,
  input  wire logic        success_i,
  input  wire logic [31:0] now_secs_i,
  input  wire logic [15:0] random_value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       chosen_slot_o,
  output logic [1:0]       status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int RQW = $bits(harrs_pkg::req_t);
  localparam int RSW = $bits(harrs_pkg::res_t);

  harrs_pkg::cfg_t cfg_q;
  harrs_pkg::req_t rq_in, rq_out;
  harrs_pkg::res_t rs_in, rs_out;
  logic rq_empty, rq_pop, rs_push, rs_full;

  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fail_window: 16'd60, check_intv: 16'd60, consec_lim: 16'd5,
                 retry_intv: 16'd30, min_calls: 16'd2, err_ratio: 9'd128};
    end else if (cfg_valid_i) begin
      unique case (harrs_pkg::cfg_idx_e'(cfg_index_i))
        harrs_pkg::CFG_FAIL_WINDOW: cfg_q.fail_window <= cfg_data_i;
        harrs_pkg::CFG_CHECK_INTV:  cfg_q.check_intv  <= cfg_data_i;
        harrs_pkg::CFG_CONSEC_LIM:  cfg_q.consec_lim  <= cfg_data_i;
        harrs_pkg::CFG_RETRY_INTV:  cfg_q.retry_intv  <= cfg_data_i;
        harrs_pkg::CFG_MIN_CALLS:   cfg_q.min_calls   <= cfg_data_i;
        harrs_pkg::CFG_ERR_RATIO:   cfg_q.err_ratio   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign rq_in = '{op: harrs_pkg::op_e'(opcode_i), slot: node_slot_i, ok: success_i,
                   now: now_secs_i, rnd: random_value_i};

  logic rq_full;
  assign full = rq_full;

  harrs_fifo #(.W(RQW)) u_req_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(rq_in), .full_o(rq_full),
    .pop_i(rq_pop), .data_o(rq_out), .empty_o(rq_empty)
  );

  harrs_back #(.NUM_SLOTS(NUM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .req_valid_i(!rq_empty), .req_i(rq_out),
    .req_pop_o(rq_pop), .res_push_o(rs_push), .res_o(rs_in), .res_full_i(rs_full)
  );

  harrs_fifo #(.W(RSW)) u_res_q (
    .clk_i, .rst_ni, .push_i(rs_push), .data_i(rs_in), .full_o(rs_full),
    .pop_i(pop), .data_o(rs_out), .empty_o(empty)
  );

  assign chosen_slot_o = rs_out.chosen;
  assign status_o      = rs_out.status;
endmodule
`default_nettype wire
